FILE: hdl/vnrt_pkg.sv
// Shared constants and types for the value noise rock texel generator.
`timescale 1ns / 1ps

package vnrt_pkg;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MIX   = 32'd1274126177;

    localparam logic [7:0] RED_LO   = 8'd38;
    localparam logic [7:0] RED_HI   = 8'd178;
    localparam logic [7:0] GREEN_LO = 8'd34;
    localparam logic [7:0] GREEN_HI = 8'd166;
    localparam logic [7:0] BLUE_LO  = 8'd30;
    localparam logic [7:0] BLUE_HI  = 8'd150;

    localparam logic [3:0] SIZE_LOG2_RESET = 4'd8;

    // Lowest lattice frequency is 4, so octave o has o + 2 lattice bits.
    localparam int BASE_FREQ_LOG2 = 2;

    // Per-stage load enables of the pipeline.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
        logic s8;
    } adv_t;

endpackage

FILE: hdl/vnrt_octave.sv
// One octave lane: lattice corners, hash, smoothstep weights and bilinear blend.
`timescale 1ns / 1ps

module vnrt_octave #(
    parameter int OCT = 0
) (
    input  logic               aclk,
    input  vnrt_pkg::adv_t     adv,
    input  logic [15:0]        xn,
    input  logic [15:0]        yn,
    output logic [15:0]        oct_val
);

    localparam int K = OCT + vnrt_pkg::BASE_FREQ_LOG2;

    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] t);
        logic [32:0] acc;
        acc = 33'(a) * (33'd65536 - 33'(t)) + 33'(b) * 33'(t);
        return acc[31:16];
    endfunction

    // Stage 2
    logic [K-1:0]  x0, x1, y0, y1;
    logic [15:0]   fx, fy;
    logic [31:0]   fx_sq, fy_sq;
    logic [31:0]   px0_reg, px1_reg, py0_reg, py1_reg;
    logic [15:0]   fx_reg, fy_reg, f2x_reg, f2y_reg;

    assign x0 = xn[15 -: K];
    assign y0 = yn[15 -: K];
    assign x1 = x0 + K'(1);
    assign y1 = y0 + K'(1);
    assign fx = 16'(32'(xn) << K);
    assign fy = 16'(32'(yn) << K);
    assign fx_sq = 32'(fx) * 32'(fx);
    assign fy_sq = 32'(fy) * 32'(fy);

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            px0_reg <= 32'(x0) * vnrt_pkg::HASH_MUL_X;
            px1_reg <= 32'(x1) * vnrt_pkg::HASH_MUL_X;
            py0_reg <= 32'(y0) * vnrt_pkg::HASH_MUL_Y;
            py1_reg <= 32'(y1) * vnrt_pkg::HASH_MUL_Y;
            fx_reg  <= fx;
            fy_reg  <= fy;
            f2x_reg <= fx_sq[31:16];
            f2y_reg <= fy_sq[31:16];
        end
    end

    // Stage 3: corner sums with the first fold, and the smoothstep product.
    logic [31:0] h00, h10, h01, h11;
    logic [33:0] smx, smy;
    logic [31:0] g00_reg, g10_reg, g01_reg, g11_reg;
    logic [15:0] sx3_reg, sy3_reg;

    assign h00 = px0_reg + py0_reg;
    assign h10 = px1_reg + py0_reg;
    assign h01 = px0_reg + py1_reg;
    assign h11 = px1_reg + py1_reg;
    assign smx = 34'(f2x_reg) * (34'd196608 - 34'({fx_reg, 1'b0}));
    assign smy = 34'(f2y_reg) * (34'd196608 - 34'({fy_reg, 1'b0}));

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            g00_reg <= h00 ^ (h00 >> 13);
            g10_reg <= h10 ^ (h10 >> 13);
            g01_reg <= h01 ^ (h01 >> 13);
            g11_reg <= h11 ^ (h11 >> 13);
            sx3_reg <= smx[31:16];
            sy3_reg <= smy[31:16];
        end
    end

    // Stage 4: hash multiply.
    logic [31:0] m00_reg, m10_reg, m01_reg, m11_reg;
    logic [15:0] sx4_reg, sy4_reg;

    always_ff @(posedge aclk) begin
        if (adv.s4) begin
            m00_reg <= g00_reg * vnrt_pkg::HASH_MIX;
            m10_reg <= g10_reg * vnrt_pkg::HASH_MIX;
            m01_reg <= g01_reg * vnrt_pkg::HASH_MIX;
            m11_reg <= g11_reg * vnrt_pkg::HASH_MIX;
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
        end
    end

    // Stage 5: final fold gives corner values, blended along x.
    logic [15:0] v00, v10, v01, v11;
    logic [15:0] top_reg, bot_reg, sy5_reg;

    assign v00 = m00_reg[15:0] ^ m00_reg[31:16];
    assign v10 = m10_reg[15:0] ^ m10_reg[31:16];
    assign v01 = m01_reg[15:0] ^ m01_reg[31:16];
    assign v11 = m11_reg[15:0] ^ m11_reg[31:16];

    always_ff @(posedge aclk) begin
        if (adv.s5) begin
            top_reg <= blend(v00, v10, sx4_reg);
            bot_reg <= blend(v01, v11, sx4_reg);
            sy5_reg <= sy4_reg;
        end
    end

    // Stage 6: blend along y and scale by the octave amplitude.
    logic [15:0] oct_reg;

    always_ff @(posedge aclk) begin
        if (adv.s6) begin
            oct_reg <= blend(top_reg, bot_reg, sy5_reg) >> (OCT + 1);
        end
    end

    assign oct_val = oct_reg;

endmodule

FILE: hdl/vnrt_tint.sv
// Octave sum with saturation, then the grey tint of the three colour channels.
`timescale 1ns / 1ps

module vnrt_tint #(
    parameter int OCTAVE_COUNT = 5
) (
    input  logic                               aclk,
    input  vnrt_pkg::adv_t                     adv,
    input  logic [OCTAVE_COUNT-1:0][15:0]      oct_val,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue
);

    localparam int SUM_W = 16 + $clog2(OCTAVE_COUNT + 1);

    function automatic logic [7:0] tint(input logic [7:0] lo, input logic [7:0] hi,
                                        input logic [15:0] n);
        logic [23:0] prod;
        prod = 24'(hi - lo) * 24'(n);
        return lo + prod[23:16];
    endfunction

    logic [SUM_W-1:0] total;
    logic [15:0]      sum_reg;
    logic [7:0]       red_reg, green_reg, blue_reg;

    always_comb begin
        total = '0;
        for (int i = 0; i < OCTAVE_COUNT; i++) begin
            total = total + SUM_W'(oct_val[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s7) begin
            sum_reg <= (total > SUM_W'(16'hffff)) ? 16'hffff : total[15:0];
        end
        if (adv.s8) begin
            red_reg   <= tint(vnrt_pkg::RED_LO, vnrt_pkg::RED_HI, sum_reg);
            green_reg <= tint(vnrt_pkg::GREEN_LO, vnrt_pkg::GREEN_HI, sum_reg);
            blue_reg  <= tint(vnrt_pkg::BLUE_LO, vnrt_pkg::BLUE_HI, sum_reg);
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: hdl/value_noise_rock_texel.sv
// Top level of the value noise rock texel generator.
`timescale 1ns / 1ps

// Takes one texel coordinate per word and returns its rock colour, built from
// OCTAVE_COUNT octaves of tileable value noise. The block accepts one word every
// clock cycle unless back-pressure has filled the pipeline. Results pass through
// eight register stages (coordinate scaling, five hash and blend stages per octave
// lane, octave sum and colour tint). Each stage holds its word under back-pressure,
// so gaps close up and nothing is dropped. The user must write size_log2 through
// the cfg port only while no word is in flight; the block does not enforce it.

module value_noise_rock_texel #(
    parameter int OCTAVE_COUNT = 5,
    parameter int COORD_BITS   = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [3:0]                   cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,   // texel_x, texel_y, zero pad
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata          // red, green, blue
);

    localparam int STAGES = 8;

    logic [3:0]             size_log2_reg;
    logic [STAGES:1]        valid_reg;
    logic [STAGES:1]        rdy;
    logic [4:0]             s_eff;
    logic [COORD_BITS-1:0]  texel_x, texel_y;
    logic [15:0]            xn_reg, yn_reg;
    vnrt_pkg::adv_t         adv;
    logic [OCTAVE_COUNT-1:0][15:0] oct_val;
    logic [7:0]             red, green, blue;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg <= vnrt_pkg::SIZE_LOG2_RESET;
        end else if (cfg_valid && cfg_ready) begin
            size_log2_reg <= cfg_data;
        end
    end

    // A stage may load when it is empty or its word moves on.
    always_comb begin
        rdy[STAGES] = !valid_reg[STAGES] || m_tready;
        for (int i = STAGES - 1; i >= 1; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[1]) valid_reg[1] <= s_tvalid;
            for (int i = 2; i <= STAGES; i++) begin
                if (rdy[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    assign adv = '{s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5],
                   s6: rdy[6], s7: rdy[7], s8: rdy[8]};

    assign s_tready = rdy[1];
    assign m_tvalid = valid_reg[STAGES];

    // Effective edge size, clamped to the legal range.
    always_comb begin
        s_eff = 5'(size_log2_reg);
        if (s_eff == 5'd0) s_eff = 5'd1;
        if (s_eff > 5'(COORD_BITS)) s_eff = 5'(COORD_BITS);
    end

    assign texel_x = s_tdata[COORD_BITS-1:0];
    assign texel_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

    // Coordinates as Q0.16 fractions of the edge; bits above the size drop out.
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            xn_reg <= 16'((32'(texel_x) << 16) >> s_eff);
            yn_reg <= 16'((32'(texel_y) << 16) >> s_eff);
        end
    end

    for (genvar o = 0; o < OCTAVE_COUNT; o++) begin : g_oct
        vnrt_octave #(.OCT(o)) u_octave (
            .aclk    (aclk),
            .adv     (adv),
            .xn      (xn_reg),
            .yn      (yn_reg),
            .oct_val (oct_val[o])
        );
    end

    vnrt_tint #(.OCTAVE_COUNT(OCTAVE_COUNT)) u_tint (
        .aclk    (aclk),
        .adv     (adv),
        .oct_val (oct_val),
        .red     (red),
        .green   (green),
        .blue    (blue)
    );

    assign m_tdata = {blue, green, red};

    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[1] |-> s_tready)
        else $error("input stage empty but not ready");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[1])
        else $error("accepted word lost at first stage");

    a_colour_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (red >= vnrt_pkg::RED_LO) && (red <= vnrt_pkg::RED_HI) &&
                     (blue >= vnrt_pkg::BLUE_LO) && (blue <= vnrt_pkg::BLUE_HI))
        else $error("colour outside tint range");

endmodule
